FILE: rtl/tcprto_pkg.sv
// ----------------------------------------------------------------------------
// tcprto_pkg
// Shared types and constants for the TCP retransmit timer / RTO estimator.
// ----------------------------------------------------------------------------
package tcprto_pkg;

  localparam int DEFAULT_TIME_WIDTH = 32;

  localparam int OPCODE_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int OUT_W     = 32;

  localparam int FAST_TICK_W = 10;
  localparam int GRAN_W      = 16;
  localparam int SHIFT_W     = 3;

  // register reset values
  localparam logic [FAST_TICK_W-1:0] FAST_TICK_RST = 10'd200;
  localparam logic [31:0]            RTO_MIN_RST   = 32'd1000;
  localparam logic [31:0]            RTO_MAX_RST   = 32'd60000;
  localparam logic [GRAN_W-1:0]      GRAN_RST      = 16'd1;
  localparam logic [SHIFT_W-1:0]     ALPHA_RST     = 3'd3;
  localparam logic [SHIFT_W-1:0]     BETA_RST      = 3'd2;
  localparam logic [31:0]            INIT_RTO_RST  = 32'd1000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_FAST_TICK  = 3'd0,
    OP_SLOW_CHECK = 3'd1,
    OP_ARM        = 3'd2,
    OP_MEASURE    = 3'd3,
    OP_DISARM     = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_TICK = 3'd0,
    CFG_RTO_MIN   = 3'd1,
    CFG_RTO_MAX   = 3'd2,
    CFG_GRAN      = 3'd3,
    CFG_ALPHA     = 3'd4,
    CFG_BETA      = 3'd5,
    CFG_INIT_RTO  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [FAST_TICK_W-1:0] fast_tick_ms;
    logic [31:0]            rto_min_ms;
    logic [31:0]            rto_max_ms;
    logic [GRAN_W-1:0]      granularity_ms;
    logic [SHIFT_W-1:0]     alpha_shift;
    logic [SHIFT_W-1:0]     beta_shift;
  } cfg_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                connection_established;
    logic                ack_pending;
  } item_t;

  typedef struct packed {
    logic             send_ack;
    logic             resend_segment;
    logic [OUT_W-1:0] clock_now;
    logic [OUT_W-1:0] timeout_now;
    logic [OUT_W-1:0] smoothed_rtt_now;
    logic [OUT_W-1:0] rtt_variance_now;
    logic             timer_armed;
  } result_t;

endpackage

FILE: rtl/tcprto_if.sv
// ----------------------------------------------------------------------------
// tcprto_if
// Valid/ready channels: request items, result items and register writes.
// ----------------------------------------------------------------------------
interface tcprto_req_if
  import tcprto_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                connection_established;
  logic                ack_pending;

  modport source(output valid, opcode, connection_established, ack_pending, input ready);
  modport sink(input valid, opcode, connection_established, ack_pending, output ready);
endinterface

interface tcprto_rsp_if
  import tcprto_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             send_ack;
  logic             resend_segment;
  logic [OUT_W-1:0] clock_now;
  logic [OUT_W-1:0] timeout_now;
  logic [OUT_W-1:0] smoothed_rtt_now;
  logic [OUT_W-1:0] rtt_variance_now;
  logic             timer_armed;

  modport source(output valid, send_ack, resend_segment, clock_now, timeout_now,
                 smoothed_rtt_now, rtt_variance_now, timer_armed, input ready);
  modport sink(input valid, send_ack, resend_segment, clock_now, timeout_now,
               smoothed_rtt_now, rtt_variance_now, timer_armed, output ready);
endinterface

interface tcprto_cfg_if
  import tcprto_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/tcp_retransmit_timer_rto.sv
// ----------------------------------------------------------------------------
// tcp_retransmit_timer_rto
// Retransmission timer and RTO estimator for one TCP connection.
//
//   channel | dir | payload                                      | transfer when
//   --------+-----+----------------------------------------------+--------------
//   req     | in  | opcode, connection_established, ack_pending  | valid & ready
//   rsp     | out | send_ack, resend_segment, *_now, timer_armed | valid & ready
//   cfg     | in  | index, data (register write)                 | valid & ready
//
// One item per cycle unless a stalled result holds the flow; the request passes the input
// register, then the result register written with the new state, which makes the result valid.
// The RTO update path (sample, smoothing, RTO clamp) sits in one stage, ahead of the result register.
// rst is synchronous; cfg.ready is always high.
// A stalled result holds the pipeline; one more item waits in the input register.
// ----------------------------------------------------------------------------
module tcp_retransmit_timer_rto
  import tcprto_pkg::*;
#(
  parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  tcprto_req_if.sink    req,
  tcprto_rsp_if.source  rsp,
  tcprto_cfg_if.sink    cfg
);

  cfg_t    regs;
  item_t   item;
  result_t result;
  logic    item_vld;
  logic    out_vld;
  logic    advance;
  logic    req_xfer;

  tcprto_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign advance   = item_vld && (!out_vld || rsp.ready);
  assign req.ready = !item_vld || advance;
  assign req_xfer  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      if (req_xfer) begin
        item_vld <= 1'b1;
      end else if (advance) begin
        item_vld <= 1'b0;
      end
      if (advance) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      item.opcode                 <= req.opcode;
      item.connection_established <= req.connection_established;
      item.ack_pending            <= req.ack_pending;
    end
  end

  tcprto_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .regs    (regs),
    .result  (result)
  );

  assign rsp.valid            = out_vld;
  assign rsp.send_ack         = result.send_ack;
  assign rsp.resend_segment   = result.resend_segment;
  assign rsp.clock_now        = result.clock_now;
  assign rsp.timeout_now      = result.timeout_now;
  assign rsp.smoothed_rtt_now = result.smoothed_rtt_now;
  assign rsp.rtt_variance_now = result.rtt_variance_now;
  assign rsp.timer_armed      = result.timer_armed;

endmodule

FILE: rtl/tcprto_cfg.sv
// ----------------------------------------------------------------------------
// tcprto_cfg
// Configuration register file, written through the register write channel.
// ----------------------------------------------------------------------------
module tcprto_cfg
  import tcprto_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  tcprto_cfg_if.sink   cfg,
  output cfg_t         regs
);

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fast_tick_ms   <= FAST_TICK_RST;
      regs.rto_min_ms     <= RTO_MIN_RST;
      regs.rto_max_ms     <= RTO_MAX_RST;
      regs.granularity_ms <= GRAN_RST;
      regs.alpha_shift    <= ALPHA_RST;
      regs.beta_shift     <= BETA_RST;
    end else if (wr) begin
      unique case (cfg_idx_e'(cfg.index))
        CFG_FAST_TICK: regs.fast_tick_ms   <= cfg.data[FAST_TICK_W-1:0];
        CFG_RTO_MIN:   regs.rto_min_ms     <= cfg.data[31:0];
        CFG_RTO_MAX:   regs.rto_max_ms     <= cfg.data[31:0];
        CFG_GRAN:      regs.granularity_ms <= cfg.data[GRAN_W-1:0];
        CFG_ALPHA:     regs.alpha_shift    <= cfg.data[SHIFT_W-1:0];
        CFG_BETA:      regs.beta_shift     <= cfg.data[SHIFT_W-1:0];
        // initial RTO only matters at reset, and reset restores its default
        CFG_INIT_RTO:  ;
        default:       ;
      endcase
    end
  end

endmodule

FILE: rtl/tcprto_core.sv
// ----------------------------------------------------------------------------
// tcprto_core
// Timer state, next-state logic for one item and the result register.
// ----------------------------------------------------------------------------
module tcprto_core
  import tcprto_pkg::*;
#(
  parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    regs,
  output result_t result
);

  localparam int          TW      = TIME_WIDTH;
  localparam logic [63:0] TMASK64 = (64'd1 << TW) - 64'd1;
  localparam logic [TW-1:0] ONES  = '1;

  function automatic logic [TW-1:0] sat_t(input logic [31:0] x);
    logic [63:0] x64;
    x64 = 64'(x);
    return (x64 > TMASK64) ? ONES : x64[TW-1:0];
  endfunction

  // floor((old*(2^s-1) + x) / 2^s) without a wide product
  function automatic logic [TW-1:0] smooth(input logic [TW-1:0] old,
                                           input logic [TW-1:0] x,
                                           input logic [SHIFT_W-1:0] s);
    logic [TW-1:0] d;
    logic [TW-1:0] mask;
    logic [TW-1:0] q;
    logic [TW-1:0] res;
    mask = (TW'(1) << s) - TW'(1);
    if (x >= old) begin
      res = old + ((x - old) >> s);
    end else begin
      d   = old - x;
      q   = (d >> s) + TW'((d & mask) != '0);
      res = old - q;
    end
    return res;
  endfunction

  logic [TW-1:0] clock_ms, timeout_ms, deadline_ms, smoothed_rtt, rtt_variance;
  logic [TW-1:0] clock_next, timeout_next, deadline_next, srtt_next, var_next;
  logic          ack, resend;

  // measurement path
  logic [TW-1:0] m_start, m_sample, m_diff, m_var, m_srtt, m_k, m_gran, m_rto_min;
  logic [TW:0]   m_sum;
  logic [TW-1:0] m_rto;

  always_comb begin
    m_start  = deadline_ms - timeout_ms;
    m_sample = clock_ms - m_start;
    if (m_sample[TW-1]) begin
      m_sample = '0;
    end
    m_diff = (smoothed_rtt >= m_sample) ? smoothed_rtt - m_sample
                                        : m_sample - smoothed_rtt;
    if (smoothed_rtt == '0) begin
      m_srtt = m_sample;
      m_var  = m_sample >> 1;
    end else begin
      m_var  = smooth(rtt_variance, m_diff, regs.beta_shift);
      m_srtt = smooth(smoothed_rtt, m_sample, regs.alpha_shift);
    end
    m_k      = (m_var[TW-1:TW-2] != 2'b00) ? ONES : (m_var << 2);
    m_gran   = TW'(regs.granularity_ms);
    if (m_k < m_gran) begin
      m_k = m_gran;
    end
    m_sum     = {1'b0, m_srtt} + {1'b0, m_k};
    m_rto     = m_sum[TW] ? ONES : m_sum[TW-1:0];
    m_rto_min = sat_t(regs.rto_min_ms);
    if (m_rto < m_rto_min) begin
      m_rto = m_rto_min;
    end
  end

  // backoff path
  logic [TW-1:0] b_rto, b_max;
  logic          b_fire;

  always_comb begin
    b_fire = item.connection_established && (deadline_ms != '0) &&
             (deadline_ms < clock_ms);
    b_rto  = timeout_ms[TW-1] ? ONES : (timeout_ms << 1);
    b_max  = sat_t(regs.rto_max_ms);
    if (b_rto > b_max) begin
      b_rto = b_max;
    end
  end

  always_comb begin
    clock_next    = clock_ms;
    timeout_next  = timeout_ms;
    deadline_next = deadline_ms;
    srtt_next     = smoothed_rtt;
    var_next      = rtt_variance;
    ack           = 1'b0;
    resend        = 1'b0;
    unique case (item.opcode)
      OP_FAST_TICK: begin
        ack        = item.connection_established && item.ack_pending;
        clock_next = clock_ms + TW'(regs.fast_tick_ms);
      end
      OP_SLOW_CHECK: begin
        if (b_fire) begin
          timeout_next  = b_rto;
          deadline_next = clock_ms + b_rto;
          resend        = 1'b1;
        end
      end
      OP_ARM: begin
        deadline_next = clock_ms + timeout_ms;
      end
      OP_MEASURE: begin
        srtt_next    = m_srtt;
        var_next     = m_var;
        timeout_next = m_rto;
      end
      OP_DISARM: begin
        deadline_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms     <= '0;
      timeout_ms   <= sat_t(INIT_RTO_RST);
      deadline_ms  <= '0;
      smoothed_rtt <= '0;
      rtt_variance <= '0;
    end else if (advance) begin
      clock_ms     <= clock_next;
      timeout_ms   <= timeout_next;
      deadline_ms  <= deadline_next;
      smoothed_rtt <= srtt_next;
      rtt_variance <= var_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.send_ack         <= ack;
      result.resend_segment   <= resend;
      result.clock_now        <= OUT_W'(clock_next);
      result.timeout_now      <= OUT_W'(timeout_next);
      result.smoothed_rtt_now <= OUT_W'(srtt_next);
      result.rtt_variance_now <= OUT_W'(var_next);
      result.timer_armed      <= (deadline_next != '0);
    end
  end

endmodule

FILE: rtl/tcprto_checker.sv
// ----------------------------------------------------------------------------
// tcprto_checker
// Port-level checks for the retransmit timer, bound to the top level.
// ----------------------------------------------------------------------------
module tcprto_checker
  import tcprto_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic             send_ack,
  input logic             resend_segment,
  input logic [OUT_W-1:0] clock_now,
  input logic [OUT_W-1:0] timeout_now
);

  logic [1:0] pending;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  // items taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (req_xfer && !rsp_xfer) begin
      pending <= pending + 2'd1;
    end else if (rsp_xfer && !req_xfer) begin
      pending <= pending - 2'd1;
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two items in flight");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result shown with no item outstanding");

  a_rsp_valid_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_payload_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(send_ack) && $stable(resend_segment) &&
                                $stable(clock_now) && $stable(timeout_now))
    else $error("result changed while stalled");

endmodule

bind tcp_retransmit_timer_rto tcprto_checker u_tcprto_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .send_ack       (rsp.send_ack),
  .resend_segment (rsp.resend_segment),
  .clock_now      (rsp.clock_now),
  .timeout_now    (rsp.timeout_now)
);
